/* sv/srec_pkg.sv */
// shared types, codes and decode helpers for the s-record parser
package srec_pkg;

	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_F    = 8'h46;

	typedef enum logic [2:0] {
		KIND_TYPE     = 3'd0,
		KIND_COUNT    = 3'd1,
		KIND_ADDR     = 3'd2,
		KIND_DATA     = 3'd3,
		KIND_CHECKSUM = 3'd4,
		KIND_DROP     = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  record_type;
		logic        type_invalid;
		logic [2:0]  address_bytes;
		logic [7:0]  byte_count;
		logic [31:0] address;
		logic [7:0]  data_byte;
		logic        checksum_ok;
		logic [7:0]  computed_checksum;
	} res_t;

	// address length in bytes for a record type
	function automatic logic [2:0] addr_len(input logic [3:0] t);
		logic [2:0] n;
		case (t)
			4'd2, 4'd8: n = 3'd3;
			4'd3, 4'd7: n = 3'd4;
			default:    n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) || ((c >= CHAR_A) && (c <= CHAR_F));
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c <= CHAR_NINE) begin
			v = c - CHAR_ZERO;
		end else begin
			v = c - CHAR_A + 8'd10;
		end
		return v[3:0];
	endfunction

endpackage

/* sv/srec_core.sv */
// record state machine: updates parse state for one character, forms the result
module srec_core import srec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] ch,
	output logic       emit,
	output res_t       res
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TYPE  = 3'd1,
		PH_COUNT = 3'd2,
		PH_ADDR  = 3'd3,
		PH_DATA  = 3'd4
	} phase_t;

	phase_t      phase_q, phase_n;
	logic        high_pending_q, high_pending_n;
	logic [3:0]  held_q, held_n;
	logic [3:0]  type_q, type_n;
	logic [2:0]  addr_left_q, addr_left_n;
	logic [9:0]  bytes_left_q, bytes_left_n;
	logic [31:0] addr_acc_q, addr_acc_n;
	logic [7:0]  sum_q, sum_n;

	logic [3:0]  nib;
	logic [7:0]  b;
	logic [3:0]  t_new;
	logic        t_bad;
	logic [7:0]  calc;

	assign nib  = hex_nibble(ch);
	assign b    = {held_q, nib};
	assign calc = ~sum_q;

	always_comb begin
		t_bad = 1'b0;
		case (nib)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd8, 4'd9: t_bad = 1'b0;
			default: t_bad = 1'b1;
		endcase
		t_new = t_bad ? 4'd1 : nib;
	end

	always_comb begin
		phase_n        = phase_q;
		high_pending_n = high_pending_q;
		held_n         = held_q;
		type_n         = type_q;
		addr_left_n    = addr_left_q;
		bytes_left_n   = bytes_left_q;
		addr_acc_n     = addr_acc_q;
		sum_n          = sum_q;
		emit           = 1'b0;
		res            = '0;
		res.kind       = KIND_TYPE;

		if (ch == CHAR_S) begin
			// a half-received byte is dropped and reported
			if (!high_pending_q) begin
				emit              = 1'b1;
				res.kind          = KIND_DROP;
				res.record_type   = type_q;
				res.address_bytes = addr_len(type_q);
				res.data_byte     = {4'd0, held_q};
			end
			sum_n          = '0;
			high_pending_n = 1'b1;
			phase_n        = PH_TYPE;
		end else if (is_hex(ch)) begin
			if (phase_q == PH_TYPE) begin
				type_n            = t_new;
				addr_left_n       = addr_len(t_new);
				addr_acc_n        = '0;
				phase_n           = PH_COUNT;
				emit              = 1'b1;
				res.kind          = KIND_TYPE;
				res.record_type   = t_new;
				res.type_invalid  = t_bad;
				res.address_bytes = addr_len(t_new);
			end else if (high_pending_q) begin
				held_n         = nib;
				high_pending_n = 1'b0;
			end else begin
				high_pending_n    = 1'b1;
				res.record_type   = type_q;
				res.address_bytes = addr_len(type_q);
				case (phase_q)
					PH_COUNT: begin
						bytes_left_n   = {2'd0, b};
						sum_n          = sum_q + b;
						phase_n        = PH_ADDR;
						emit           = 1'b1;
						res.kind       = KIND_COUNT;
						res.byte_count = b;
					end
					PH_ADDR: begin
						addr_acc_n   = {addr_acc_q[23:0], b};
						sum_n        = sum_q + b;
						bytes_left_n = bytes_left_q - 10'd1;
						addr_left_n  = addr_left_q - 3'd1;
						if (addr_left_n == 3'd0) begin
							phase_n     = PH_DATA;
							emit        = 1'b1;
							res.kind    = KIND_ADDR;
							res.address = addr_acc_n;
						end
					end
					PH_DATA: begin
						bytes_left_n  = bytes_left_q - 10'd1;
						emit          = 1'b1;
						res.address   = addr_acc_q;
						res.data_byte = b;
						// the byte on which the counter runs out is the checksum
						if (bytes_left_n == 10'd0) begin
							res.kind              = KIND_CHECKSUM;
							res.checksum_ok       = (b == calc);
							res.computed_checksum = calc;
							phase_n               = PH_IDLE;
						end else begin
							res.kind = KIND_DATA;
							sum_n    = sum_q + b;
						end
					end
					default: begin
						// idle: pairs are assembled but give nothing
						emit = 1'b0;
						res  = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			high_pending_q <= 1'b1;
			held_q         <= '0;
			type_q         <= '0;
			addr_left_q    <= '0;
			bytes_left_q   <= '0;
			addr_acc_q     <= '0;
			sum_q          <= '0;
		end else if (en) begin
			phase_q        <= phase_n;
			high_pending_q <= high_pending_n;
			held_q         <= held_n;
			type_q         <= type_n;
			addr_left_q    <= addr_left_n;
			bytes_left_q   <= bytes_left_n;
			addr_acc_q     <= addr_acc_n;
			sum_q          <= sum_n;
		end
	end

	a_addr_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ADDR) |-> (addr_left_q != 3'd0 && addr_left_q <= 3'd4))
		else $error("address byte counter out of range");

	a_type_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (type_q == 4'd0 || type_q == 4'd1 || type_q == 4'd2 ||
			type_q == 4'd3 || type_q == 4'd7 || type_q == 4'd8 || type_q == 4'd9))
		else $error("stored record type is not a legal type");

	a_s_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ch == CHAR_S) |=> (phase_q == PH_TYPE && high_pending_q && sum_q == 8'd0))
		else $error("record start did not reset parse state");

endmodule

/* sv/srecord_char_parser.sv */
// top level of the s-record character parser: input and result registers around the core
//
// Usage:
//   Characters enter on the char channel (char_valid, char_stall, in_char), one per
//   transfer. Each parsed event leaves on the rec channel (rec_valid, rec_stall and
//   the result fields) as one transfer; many characters give no result at all.
//   A character is taken into an input register, processed by the record state
//   machine once the result register is free or draining, and its result, if any,
//   is loaded into the result register at the end of that cycle, which drives
//   rec_valid. Throughput is one character per clock while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input register
//   keeps its character; char_stall rises only when both are occupied, so one
//   extra character is still taken while a result waits.
//   Reset (arst_n low) empties both registers and returns the parser to idle
//   with a high nibble expected and the checksum cleared.
module srecord_char_parser import srec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  in_char,
	output logic        rec_valid,
	input  logic        rec_stall,
	output logic [2:0]  kind,
	output logic [3:0]  record_type,
	output logic        type_invalid,
	output logic [2:0]  address_bytes,
	output logic [7:0]  byte_count,
	output logic [31:0] address,
	output logic [7:0]  data_byte,
	output logic        checksum_ok,
	output logic [7:0]  computed_checksum
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic       advance;
	logic       core_en;
	logic       emit;
	res_t       res;

	assign advance    = !valid_s2 || !rec_stall;
	assign char_stall = valid_s1 && !advance;
	assign core_en    = valid_s1 && advance;

	srec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (core_en),
		.ch     (char_s1),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= char_valid;
			end
			if (advance) begin
				valid_s2 <= core_en && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= in_char;
		end
		if (core_en && emit) begin
			res_s2 <= res;
		end
	end

	assign rec_valid         = valid_s2;
	assign kind              = res_s2.kind;
	assign record_type       = res_s2.record_type;
	assign type_invalid      = res_s2.type_invalid;
	assign address_bytes     = res_s2.address_bytes;
	assign byte_count        = res_s2.byte_count;
	assign address           = res_s2.address;
	assign data_byte         = res_s2.data_byte;
	assign checksum_ok       = res_s2.checksum_ok;
	assign computed_checksum = res_s2.computed_checksum;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (valid_s2 && rec_stall))
		else $error("input stalled while the result register could drain");

	a_checksum_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == KIND_CHECKSUM) |->
			(res_s2.checksum_ok == (res_s2.data_byte == res_s2.computed_checksum)))
		else $error("checksum flag disagrees with compared bytes");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rec_stall) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result register changed");

	a_addr_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.address_bytes == addr_len(res_s2.record_type)))
		else $error("address length does not follow record type");

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the s-record character parser
module tb_top import srec_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		P_IDLE,
		P_TYPE,
		P_COUNT,
		P_ADDR,
		P_DATA
	} parse_phase_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  in_char = 8'h00;
	logic        rec_valid;
	logic        rec_stall = 1'b0;
	logic [2:0]  kind;
	logic [3:0]  record_type;
	logic        type_invalid;
	logic [2:0]  address_bytes;
	logic [7:0]  byte_count;
	logic [31:0] address;
	logic [7:0]  data_byte;
	logic        checksum_ok;
	logic [7:0]  computed_checksum;

	srecord_char_parser u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.char_valid        (char_valid),
		.char_stall        (char_stall),
		.in_char           (in_char),
		.rec_valid         (rec_valid),
		.rec_stall         (rec_stall),
		.kind              (kind),
		.record_type       (record_type),
		.type_invalid      (type_invalid),
		.address_bytes     (address_bytes),
		.byte_count        (byte_count),
		.address           (address),
		.data_byte         (data_byte),
		.checksum_ok       (checksum_ok),
		.computed_checksum (computed_checksum)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	logic [7:0] pending_chars[$];
	res_t       expected_events[$];
	int         active_chars = 0;
	int         chars_taken = 0;
	int         mismatches = 0;

	// parser state mirrored by the testbench
	parse_phase_t ps          = P_IDLE;
	logic         hi_next     = 1'b1;
	logic [3:0]   held        = 4'h0;
	logic [3:0]   cur_type    = 4'h0;
	logic [2:0]   addr_todo   = 3'd0;
	logic [9:0]   remaining   = 10'd0;
	logic [31:0]  addr_so_far = 32'h0;
	logic [7:0]   csum        = 8'h00;

	function automatic logic [2:0] addr_bytes_for(input logic [3:0] t);
		if (t == 4'd3 || t == 4'd7)
			return 3'd4;
		else if (t == 4'd2 || t == 4'd8)
			return 3'd3;
		return 3'd2;
	endfunction

	// {is hex digit, nibble value}
	function automatic logic [4:0] decode_hex(input logic [7:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE)
			return {1'b1, c[3:0]};
		if (c >= CHAR_A && c <= CHAR_F)
			return {1'b1, c[3:0] + 4'd9};
		return 5'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return CHAR_ZERO + 8'(n);
		return CHAR_A + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] ignored_char();
		logic [7:0] c;
		logic [4:0] d;
		do begin
			c = 8'($urandom_range(0, 255));
			d = decode_hex(c);
		end while (d[4] || c == CHAR_S);
		return c;
	endfunction

	task automatic parse_char(input logic [7:0] c);
		res_t       r;
		logic [4:0] d;
		logic [3:0] t;
		logic [7:0] b;
		logic [7:0] calc;
		logic       bad;
		r = '0;
		r.record_type = cur_type;
		r.address_bytes = addr_bytes_for(cur_type);
		d = decode_hex(c);
		if (c == CHAR_S) begin
			// a record start while half a byte is held drops that nibble
			if (!hi_next) begin
				r.kind = KIND_DROP;
				r.data_byte = {4'h0, held};
				expected_events.push_back(r);
			end
			csum = 8'h00;
			hi_next = 1'b1;
			ps = P_TYPE;
		end else if (d[4]) begin
			if (ps == P_TYPE) begin
				t = d[3:0];
				bad = !(t <= 4'd3 || t == 4'd7 || t == 4'd8 || t == 4'd9);
				if (bad)
					t = 4'd1;
				cur_type = t;
				addr_todo = addr_bytes_for(t);
				addr_so_far = 32'h0;
				ps = P_COUNT;
				r.kind = KIND_TYPE;
				r.record_type = t;
				r.type_invalid = bad;
				r.address_bytes = addr_todo;
				expected_events.push_back(r);
			end else if (hi_next) begin
				held = d[3:0];
				hi_next = 1'b0;
			end else begin
				b = {held, d[3:0]};
				hi_next = 1'b1;
				case (ps)
					P_COUNT: begin
						remaining = {2'b00, b};
						csum = csum + b;
						ps = P_ADDR;
						r.kind = KIND_COUNT;
						r.byte_count = b;
						expected_events.push_back(r);
					end
					P_ADDR: begin
						addr_so_far = {addr_so_far[23:0], b};
						csum = csum + b;
						remaining = remaining - 10'd1;
						addr_todo = addr_todo - 3'd1;
						if (addr_todo == 3'd0) begin
							ps = P_DATA;
							r.kind = KIND_ADDR;
							r.address = addr_so_far;
							expected_events.push_back(r);
						end
					end
					P_DATA: begin
						// the count running out marks the checksum byte
						remaining = remaining - 10'd1;
						r.address = addr_so_far;
						r.data_byte = b;
						if (remaining == 10'd0) begin
							calc = ~csum;
							r.kind = KIND_CHECKSUM;
							r.checksum_ok = (b == calc);
							r.computed_checksum = calc;
							ps = P_IDLE;
						end else begin
							r.kind = KIND_DATA;
							csum = csum + b;
						end
						expected_events.push_back(r);
					end
					default: begin
					end
				endcase
			end
		end
	endtask

	task automatic add_char(input logic [7:0] c);
		logic [4:0] d;
		d = decode_hex(c);
		pending_chars.push_back(c);
		if (d[4] || c == CHAR_S)
			active_chars++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_char(hex_char(b[7:4]));
		add_char(hex_char(b[3:0]));
	endtask

	task automatic emit_record(input bit damaged);
		logic [7:0] body[$];
		logic [3:0] tnib;
		logic [3:0] nib;
		logic [7:0] sum;
		logic [7:0] b;
		int         alen;
		int         ndata;
		int         fault;
		int         cut;
		int         apat;
		bit         sprinkle;
		if ($urandom_range(0, 9) == 0) begin
			tnib = 4'($urandom_range(0, 15));
		end else begin
			case ($urandom_range(0, 6))
				0: tnib = 4'd0;
				1: tnib = 4'd1;
				2: tnib = 4'd2;
				3: tnib = 4'd3;
				4: tnib = 4'd7;
				5: tnib = 4'd8;
				default: tnib = 4'd9;
			endcase
		end
		alen = int'(addr_bytes_for(tnib));
		ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
		apat = $urandom_range(0, 7);
		body.push_back(8'(alen + ndata + 1));
		for (int i = 0; i < alen; i++) begin
			if (apat == 0)
				b = 8'h00;
			else if (apat == 1)
				b = 8'hFF;
			else
				b = 8'($urandom_range(0, 255));
			body.push_back(b);
		end
		for (int i = 0; i < ndata; i++)
			body.push_back(8'($urandom_range(0, 255)));
		sum = 8'h00;
		foreach (body[i])
			sum = sum + body[i];
		body.push_back(~sum);
		fault = damaged ? $urandom_range(0, 2) : -1;
		cut = $urandom_range(0, 2 * body.size() - 1);
		if (fault == 0) begin
			body[body.size() - 1] = body[body.size() - 1] ^ 8'($urandom_range(1, 255));
		end else if (fault == 1) begin
			case ($urandom_range(0, 2))
				0: body[0] = 8'h00;
				1: body[0] = 8'hFF;
				default: body[0] = 8'($urandom_range(0, 255));
			endcase
		end
		sprinkle = ($urandom_range(0, 5) == 0);
		add_char(CHAR_S);
		add_char(hex_char(tnib));
		for (int j = 0; j < 2 * body.size(); j++) begin
			if (fault == 2 && j >= cut)
				break;
			b = body[j / 2];
			nib = (j % 2 == 0) ? b[7:4] : b[3:0];
			add_char(hex_char(nib));
			if (sprinkle && $urandom_range(0, 7) == 0)
				add_char(ignored_char());
		end
		if ($urandom_range(0, 1) == 0) begin
			add_char(8'h0D);
			add_char(8'h0A);
		end
	endtask

	// sender: bursts of transfers separated by random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else begin
			if (char_valid && !char_stall) begin
				parse_char(in_char);
				chars_taken <= chars_taken + 1;
			end
			if (!char_valid || !char_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					char_valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					char_valid <= 1'b1;
					in_char <= pending_chars.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: the stall pattern is redrawn from four modes by a tick counter, plus one long hold-off
	int rcv_tick   = 0;
	int stall_mode = 0;
	int hold_left  = 0;
	bit held_off   = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rec_stall <= 1'b1;
		end else if (!held_off && chars_taken >= 400) begin
			// sender keeps offering so both registers fill and char_stall rises
			held_off = 1'b1;
			hold_left = HOLD_CYCLES;
			rec_stall <= 1'b1;
		end else begin
			rcv_tick++;
			if (rcv_tick % 256 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: rec_stall <= 1'b0;
				1: rec_stall <= ($urandom_range(0, 3) == 0);
				2: rec_stall <= ($urandom_range(0, 3) != 0);
				default: rec_stall <= ((rcv_tick % 7) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		res_t seen;
		res_t want;
		if (arst_n && rec_valid && !rec_stall) begin
			seen.kind = kind_t'(kind);
			seen.record_type = record_type;
			seen.type_invalid = type_invalid;
			seen.address_bytes = address_bytes;
			seen.byte_count = byte_count;
			seen.address = address;
			seen.data_byte = data_byte;
			seen.checksum_ok = checksum_ok;
			seen.computed_checksum = computed_checksum;
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d type %0d addr %h data %h",
						kind, record_type, address, data_byte);
			end else begin
				want = expected_events.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"mismatch exp: kind %0d type %0d inv %0b ab %0d",
							" cnt %h addr %h data %h ok %0b cs %h"},
							want.kind, want.record_type, want.type_invalid,
							want.address_bytes, want.byte_count, want.address,
							want.data_byte, want.checksum_ok, want.computed_checksum);
						$display({"         got: kind %0d type %0d inv %0b ab %0d",
							" cnt %h addr %h data %h ok %0b cs %h"},
							seen.kind, seen.record_type, seen.type_invalid,
							seen.address_bytes, seen.byte_count, seen.address,
							seen.data_byte, seen.checksum_ok, seen.computed_checksum);
					end
				end
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (rec_valid && !rec_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	initial begin
		int sel;
		int n;
		// ignored characters, extremes of the input byte
		add_char(8'h00);
		add_char(8'hFF);
		add_char(8'h61);
		// hex pair while idle gives nothing
		add_char(CHAR_F);
		add_char(CHAR_ZERO);
		// invalid type letter, full record with good checksum
		add_char(CHAR_S);
		add_char(CHAR_A);
		add_byte(8'h03);
		add_byte(8'h12);
		add_byte(8'h34);
		add_byte(8'hB6);
		// invalid type digit, then a record start in the middle of a byte
		add_char(CHAR_S);
		add_char(CHAR_ZERO + 8'd5);
		add_char(CHAR_ZERO);
		add_char(CHAR_S);
		// zero count: the remaining-byte counter wraps
		add_char(CHAR_ZERO + 8'd7);
		add_byte(8'h00);
		add_byte(8'h12);
		n = active_chars + 1200;
		while (active_chars < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				emit_record(1'b0);
			end else if (sel < 90) begin
				emit_record(1'b1);
			end else begin
				repeat ($urandom_range(1, 6))
					add_char(8'($urandom_range(0, 255)));
			end
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_chars.size() != 0 || char_valid)
			@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
